FILE: design/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The property must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) else $error(msg);

`endif

FILE: design/rrc_pkg.sv
package rrc_pkg;

  typedef logic signed [1:0] order_t;

  localparam order_t ORDER_LT = 2'sb11;
  localparam order_t ORDER_EQ = 2'sb00;
  localparam order_t ORDER_GT = 2'sb01;

endpackage

FILE: design/rrc_divider.sv
module rrc_divider #(
  parameter int unsigned OPERAND_BITS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [OPERAND_BITS-1:0] dividend_i,
  input  logic [OPERAND_BITS-1:0] divisor_i,
  output logic                    done_o,
  output logic [OPERAND_BITS-1:0] quotient_o,
  output logic [OPERAND_BITS-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(OPERAND_BITS);
  localparam logic [CntW-1:0] CntLast = CntW'(OPERAND_BITS - 1);

  logic [OPERAND_BITS-1:0] quo_q, quo_d;
  logic [OPERAND_BITS-1:0] rem_q, rem_d;
  logic [OPERAND_BITS-1:0] dsr_q;
  logic [CntW-1:0]         cnt_q;
  logic                    run_q;
  logic                    done_q;
  logic [OPERAND_BITS:0]   trial;
  logic [OPERAND_BITS:0]   diff;
  logic                    fits;

  // One restoring shift-subtract step produces one quotient bit per cycle.
  always_comb begin
    trial = {rem_q, quo_q[OPERAND_BITS-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = ~diff[OPERAND_BITS];
    rem_d = fits ? diff[OPERAND_BITS-1:0] : trial[OPERAND_BITS-1:0];
    quo_d = {quo_q[OPERAND_BITS-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntLast;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

FILE: design/rational_ratio_compare_unit.sv
// Compares two unsigned fractions by expanding both as continued fractions in step.
// Each expansion step runs two divisions on one shared shift-subtract divider,
// one quotient bit a cycle; busy stays high until the answer is shown.
// A word with a zero denominator answers equal in the cycle after start without
// raising busy. The receiver cannot stall.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle with no word pending.
module rational_ratio_compare_unit #(
  parameter int unsigned OPERAND_BITS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [OPERAND_BITS-1:0] left_num_i,
  input  logic [OPERAND_BITS-1:0] left_den_i,
  input  logic [OPERAND_BITS-1:0] right_num_i,
  input  logic [OPERAND_BITS-1:0] right_den_i,
  output logic                    valid_o,
  output rrc_pkg::order_t         order_o
);

  import rrc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_L,
    ST_DIV_R
  } state_e;

  state_e                  state_q;
  logic [OPERAND_BITS-1:0] ld_q;
  logic [OPERAND_BITS-1:0] rn_q;
  logic [OPERAND_BITS-1:0] rd_q;
  logic [OPERAND_BITS-1:0] lq_q;
  logic [OPERAND_BITS-1:0] lr_q;
  logic                    flip_q;
  logic                    valid_q;
  order_t                  order_q;

  logic                    div_start;
  logic [OPERAND_BITS-1:0] div_dividend;
  logic [OPERAND_BITS-1:0] div_divisor;
  logic                    div_done;
  logic [OPERAND_BITS-1:0] div_quo;
  logic [OPERAND_BITS-1:0] div_rem;
  logic                    dens_nz;
  logic                    lr_zero;
  logic                    rr_zero;
  logic                    go_on;
  order_t                  verdict;

  function automatic order_t decide(input logic q_lt, input logic q_eq, input logic l_zero,
                                    input logic r_zero, input logic flip);
    order_t sense;
    if (!q_eq) begin
      sense = q_lt ? ORDER_LT : ORDER_GT;
    end else if (l_zero && r_zero) begin
      sense = ORDER_EQ;
    end else if (l_zero) begin
      sense = ORDER_LT;
    end else begin
      sense = ORDER_GT;
    end
    if (flip && sense == ORDER_LT) begin
      sense = ORDER_GT;
    end else if (flip && sense == ORDER_GT) begin
      sense = ORDER_LT;
    end
    return sense;
  endfunction

  always_comb begin
    dens_nz = (left_den_i != '0) && (right_den_i != '0);
    lr_zero = (lr_q == '0);
    rr_zero = (div_rem == '0);
    go_on   = (lq_q == div_quo) && !lr_zero && !rr_zero;
    verdict = decide(lq_q < div_quo, lq_q == div_quo, lr_zero, rr_zero, flip_q);
    case (state_q)
      ST_IDLE: begin
        div_dividend = left_num_i;
        div_divisor  = left_den_i;
        div_start    = start && dens_nz;
      end
      ST_DIV_L: begin
        div_dividend = rn_q;
        div_divisor  = rd_q;
        div_start    = div_done;
      end
      ST_DIV_R: begin
        div_dividend = ld_q;
        div_divisor  = lr_q;
        div_start    = div_done && go_on;
      end
      default: begin
        div_dividend = left_num_i;
        div_divisor  = left_den_i;
        div_start    = 1'b0;
      end
    endcase
  end

  rrc_divider #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      order_q <= ORDER_EQ;
      flip_q  <= 1'b0;
      ld_q    <= '0;
      rn_q    <= '0;
      rd_q    <= '0;
      lq_q    <= '0;
      lr_q    <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            ld_q   <= left_den_i;
            rn_q   <= right_num_i;
            rd_q   <= right_den_i;
            flip_q <= 1'b0;
            if (dens_nz) begin
              state_q <= ST_DIV_L;
            end else begin
              valid_q <= 1'b1;
              order_q <= ORDER_EQ;
            end
          end
        end
        ST_DIV_L: begin
          if (div_done) begin
            lq_q    <= div_quo;
            lr_q    <= div_rem;
            state_q <= ST_DIV_R;
          end
        end
        ST_DIV_R: begin
          if (div_done) begin
            if (go_on) begin
              ld_q    <= lr_q;
              rn_q    <= rd_q;
              rd_q    <= div_rem;
              flip_q  <= !flip_q;
              state_q <= ST_DIV_L;
            end else begin
              valid_q <= 1'b1;
              order_q <= verdict;
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign order_o = order_q;

endmodule

FILE: design/rrc_checker.sv
`include "assert_macros.svh"

module rrc_checker #(
  parameter int unsigned OPERAND_BITS = 64
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_i,
  input logic [OPERAND_BITS-1:0] left_den_i,
  input logic [OPERAND_BITS-1:0] right_den_i,
  input logic                    valid_i,
  input rrc_pkg::order_t         order_i
);

  import rrc_pkg::*;

  // An accepted word either starts work or answers on the next cycle.
  `ASSERT_ALWAYS(a_start_reacts, clk_i, rst_ni, start_i && !busy_i |=> busy_i || valid_i, "accepted word was dropped")

  // A word whose denominator is zero answers equal on the next cycle.
  `ASSERT_ALWAYS(a_zero_den, clk_i, rst_ni, start_i && !busy_i && (left_den_i == '0 || right_den_i == '0) |=> valid_i && order_i == ORDER_EQ, "zero denominator must give equal")

  // The sequencer only leaves work when it delivers the answer.
  `ASSERT_ALWAYS(a_fell_busy, clk_i, rst_ni, $fell(busy_i) |-> valid_i, "work ended without a result")

  // An answer is never shown while work is still in progress.
  `ASSERT_NEVER(a_valid_busy, clk_i, rst_ni, valid_i && busy_i, "result strobe during work")

endmodule

bind rational_ratio_compare_unit rrc_checker #(
  .OPERAND_BITS(OPERAND_BITS)
) u_rrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .left_den_i  (left_den_i),
  .right_den_i (right_den_i),
  .valid_i     (valid_o),
  .order_i     (order_o)
);
